// File: hdl/ncrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrc_pkg
// Shared constants and the 256-entry CRC lookup table for the name CRC unit.
// ----------------------------------------------------------------------------
package ncrc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 32;
	localparam int unsigned TABLE_DEPTH = 1 << BYTE_W;

	localparam logic [CRC_W-1:0]  CRC_POLY  = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0]  CRC_LOW8  = 32'hFFFF_FF00;
	localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;
	localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

	typedef logic [CRC_W-1:0] crc_word_t;
	typedef crc_word_t crc_table_t [TABLE_DEPTH];

	function automatic crc_word_t table_entry(input logic [BYTE_W-1:0] idx);
		crc_word_t v;
		v = {BYTE_MASK - idx, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[CRC_W-1]) begin
				v = v << 1;
			end else begin
				v = (v << 1) ^ CRC_POLY;
			end
		end
		return v;
	endfunction

	function automatic crc_table_t build_table();
		crc_table_t t;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			t[i] = table_entry(BYTE_W'(i));
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = build_table();
	localparam crc_word_t  CRC_START = table_entry(TERM_BYTE);

endpackage

// File: hdl/ncrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrc_in_if / ncrc_out_if
// Valid/ready channels for name bytes in and CRC results out.
// ----------------------------------------------------------------------------
interface ncrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface ncrc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;
	logic        complete;

	modport source (output valid, output crc_value, output complete, input ready);
	modport sink   (input valid, input crc_value, input complete, output ready);
endinterface

// File: hdl/name_string_crc32_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_string_crc32_unit
// Running CRC-32 (MSB first, inverted-index table variant) over name bytes.
// ----------------------------------------------------------------------------
// usage:
//   byte_in  - one character of a zero-terminated name per transfer
//   crc_out  - one result per byte: the running crc including that byte, and
//              complete set when the byte was the terminating zero
//   the zero byte closes the name and reloads the start value, so the next
//   byte begins a new name
// path: input register, then table lookup and xor into the result register
// throughput: one byte per cycle while crc_out is not held; the crc feedback
//   loop is a single table read and xor, closed in the cycle that loads the
//   result register
// reset: both registers empty, running crc at the start value
// stall: while crc_out is held, the input register keeps its byte and
//   byte_in stays ready only until that register is occupied
// ----------------------------------------------------------------------------
module name_string_crc32_unit (
	input  logic              clk,
	input  logic              arst_n,
	ncrc_in_if.sink           byte_in,
	ncrc_out_if.source        crc_out
);
	import ncrc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	crc_word_t         running_crc_q;
	logic              out_valid_q;
	crc_word_t         out_crc_q;
	logic              out_complete_q;

	logic              advance;
	logic [BYTE_W-1:0] lookup_idx;
	crc_word_t         crc_next;
	logic              is_term;

	assign advance    = valid_s1 && (!out_valid_q || crc_out.ready);
	assign lookup_idx = byte_s1 ^ running_crc_q[CRC_W-1 -: BYTE_W];
	assign crc_next   = CRC_TABLE[lookup_idx] ^ ((running_crc_q << BYTE_W) & CRC_LOW8);
	assign is_term    = (byte_s1 == TERM_BYTE);

	assign byte_in.ready     = !valid_s1 || advance;
	assign crc_out.valid     = out_valid_q;
	assign crc_out.crc_value = out_crc_q;
	assign crc_out.complete  = out_complete_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	// crc state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= CRC_START;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				running_crc_q <= is_term ? CRC_START : crc_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (crc_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_crc_q      <= crc_next;
			out_complete_q <= is_term;
		end
	end

	a_complete_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_complete_q |-> running_crc_q == CRC_START)
		else $error("running crc not reloaded after terminating byte");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && out_crc_q == $past(crc_next)
			&& out_complete_q == $past(is_term))
		else $error("result register did not take the computed crc");

	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_term |=> running_crc_q == out_crc_q)
		else $error("running crc differs from delivered crc");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled byte lost from input register");

endmodule

// File: bench/ncrc_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncrc_crc_checker
// Watches the byte and crc channels of the name crc unit. Every byte transfer
// runs through a local crc predictor and queues the crc and complete flag it
// should produce; every crc transfer is compared with the oldest entry.
// ----------------------------------------------------------------------------
module ncrc_crc_checker (
	input  logic clk,
	input  logic arst_n,
	ncrc_in_if   byte_mon,
	ncrc_out_if  crc_mon,
	output int   fail_count,
	output int   pending
);
	import ncrc_pkg::*;

	typedef struct packed {
		logic [CRC_W-1:0] crc;
		logic             done;
	} name_crc_t;

	name_crc_t        crc_expect_q [$];
	logic [CRC_W-1:0] crc_acc;
	logic [CRC_W-1:0] seed_word;

	// inverted-index lookup word, msb-first over eight bit steps
	function automatic logic [CRC_W-1:0] lut_word(input logic [BYTE_W-1:0] idx);
		logic [CRC_W-1:0] w;
		w = {~idx, 24'h000000};
		for (int k = 0; k < 8; k++) begin
			if (w[CRC_W-1]) begin
				w = w << 1;
			end else begin
				w = (w << 1) ^ CRC_POLY;
			end
		end
		return w;
	endfunction

	function automatic logic [CRC_W-1:0] next_crc(input logic [CRC_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		return lut_word(b ^ acc[31:24]) ^ {acc[23:0], 8'h00};
	endfunction

	initial seed_word = lut_word(TERM_BYTE);

	always @(posedge clk or negedge arst_n) begin
		name_crc_t want;
		name_crc_t got;
		if (!arst_n) begin
			crc_acc    = lut_word(TERM_BYTE);
			fail_count = 0;
			pending    = 0;
			crc_expect_q.delete();
		end else begin
			// result side first: a result can never come from this same edge's byte
			if (crc_mon.valid && crc_mon.ready) begin
				got.crc  = crc_mon.crc_value;
				got.done = crc_mon.complete;
				if (crc_expect_q.size() == 0) begin
					$error("unexpected crc transfer: crc_value %h complete %b",
						got.crc, got.done);
					fail_count++;
				end else begin
					want = crc_expect_q.pop_front();
					if (got.crc !== want.crc) begin
						$error("crc_value: expected %h, actual %h", want.crc, got.crc);
						fail_count++;
					end
					if (got.done !== want.done) begin
						$error("complete: expected %b, actual %b", want.done, got.done);
						fail_count++;
					end
				end
			end
			if (byte_mon.valid && byte_mon.ready) begin
				want.crc  = next_crc(crc_acc, byte_mon.data_byte);
				want.done = (byte_mon.data_byte == TERM_BYTE);
				crc_expect_q.push_back(want);
				// terminator closes the name and restarts from the seed
				crc_acc = want.done ? seed_word : want.crc;
			end
			pending = crc_expect_q.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for name_string_crc32_unit. Sends directed names
// (empty name, extreme and single-bit bytes) and then random zero-terminated
// names of mixed lengths, with random gaps and crc back-pressure and one long
// stretch without either. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
	import ncrc_pkg::*;

	localparam int NUM_BYTES   = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 8;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   bytes_sent;
	int   idle_cycles;
	bit   steady;

	ncrc_in_if  byte_ch ();
	ncrc_out_if crc_ch ();

	name_string_crc32_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch.sink),
		.crc_out (crc_ch.source)
	);

	ncrc_crc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.crc_mon    (crc_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit take_gap();
		return !steady && ($urandom_range(99) < 22);
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic put_byte(input logic [BYTE_W-1:0] b);
		while (take_gap()) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
		bytes_sent++;
		steady = (bytes_sent >= 200) && (bytes_sent < 300);
		@(negedge clk);
	endtask

	task automatic put_name(input int len);
		for (int i = 0; i < len; i++) begin
			put_byte(BYTE_W'($urandom_range(1, 255)));
		end
		put_byte(TERM_BYTE);
	endtask

	always @(negedge clk) begin
		crc_ch.ready <= !take_gap();
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (crc_ch.valid && crc_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [BYTE_W-1:0] directed [] = '{
			8'h00, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'h00,
			8'h55, 8'hAA, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h00,
			8'hFE, 8'h00, 8'h00
		};
		int len;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		bytes_sent        = 0;
		steady            = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			put_byte(directed[i]);
		end

		while (bytes_sent < NUM_BYTES) begin
			if ($urandom_range(15) == 0) begin
				len = $urandom_range(40, 64);
			end else begin
				len = $urandom_range(0, 10);
			end
			put_name(len);
		end
		byte_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
